FILE: src/four_level_page_table_walker_core_macros.svh
`ifndef FOUR_LEVEL_PAGE_TABLE_WALKER_CORE_MACROS_SVH
`define FOUR_LEVEL_PAGE_TABLE_WALKER_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk_i and quiet while rst_ni is low.
`define PTW_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and quiet while rst_ni is low.
`define PTW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/ptw_pkg.sv
`default_nettype none

package ptw_pkg;

  typedef enum logic {
    FUNC_TRANSLATE = 1'b0,
    FUNC_READ_RESP = 1'b1
  } ptw_func_e;

  typedef enum logic {
    KIND_READ_REQ  = 1'b0,
    KIND_PHYS_ADDR = 1'b1
  } ptw_kind_e;

  localparam logic [0:0] REG_PRIMARY_BASE   = 1'b0;
  localparam logic [0:0] REG_SECONDARY_BASE = 1'b1;

  typedef struct packed {
    ptw_func_e   func;
    logic [47:0] virt_addr;
    logic [63:0] read_data;
  } ptw_in_t;

  typedef struct packed {
    ptw_kind_e   kind;
    logic [51:0] address;
  } ptw_out_t;

  // One pending result: the address is base plus offset, wrapped to 52 bits.
  typedef struct packed {
    ptw_kind_e   kind;
    logic [51:0] base;
    logic [29:0] offs;
  } ptw_op_t;

endpackage

`default_nettype wire

FILE: src/ptw_fifo.sv
`default_nettype none

module ptw_fifo
  import ptw_pkg::*;
#(
  parameter int unsigned Depth = 2
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    push_i,
  input  wire ptw_op_t push_data_i,
  output logic         full_o,
  input  wire logic    pop_i,
  output logic         valid_o,
  output ptw_op_t      data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  ptw_op_t         mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign full_o  = (cnt_q == FullCnt);
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

endmodule

`default_nettype wire

FILE: src/ptw_front.sv
`default_nettype none

module ptw_front
  import ptw_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [0:0]  cfg_idx_i,
  input  wire logic [51:0] cfg_wdata_i,
  input  wire logic        accept_i,
  input  wire ptw_in_t     in_data_i,
  output logic             push_o,
  output ptw_op_t          op_o
);

  localparam logic [1:0] LVL_TOP     = 2'd0;
  localparam logic [1:0] LVL_DIR_PTR = 2'd1;
  localparam logic [1:0] LVL_DIR     = 2'd2;
  localparam logic [1:0] LVL_LEAF    = 2'd3;

  logic        busy_q, busy_d;
  logic [1:0]  level_q, level_d;
  logic [47:0] va_q, va_d;
  logic [51:0] prim_q, sec_q;
  logic [51:0] top_base;
  logic [8:0]  next_idx;
  logic [63:0] rd;

  assign rd       = in_data_i.read_data;
  assign top_base = (prim_q != '0) ? prim_q : {sec_q[51:4], 4'b0000};

  always_comb begin
    case (level_q)
      LVL_TOP:     next_idx = va_q[38:30];
      LVL_DIR_PTR: next_idx = va_q[29:21];
      LVL_DIR:     next_idx = va_q[20:12];
      default:     next_idx = '0;
    endcase
  end

  always_comb begin
    busy_d  = busy_q;
    level_d = level_q;
    va_d    = va_q;
    push_o  = 1'b0;
    op_o    = '{kind: KIND_READ_REQ, base: '0, offs: '0};
    if (accept_i) begin
      if (in_data_i.func == FUNC_TRANSLATE) begin
        if (!busy_q) begin
          push_o    = 1'b1;
          busy_d    = 1'b1;
          level_d   = LVL_TOP;
          va_d      = in_data_i.virt_addr;
          op_o.base = top_base;
          op_o.offs = {18'b0, in_data_i.virt_addr[47:39], 3'b000};
        end
      end else if (busy_q) begin
        push_o    = 1'b1;
        level_d   = level_q + 1'b1;
        op_o.base = {16'b0, rd[35:12], 12'b0};
        op_o.offs = {18'b0, next_idx, 3'b000};
        case (level_q)
          LVL_DIR_PTR: begin
            if (rd[7]) begin
              busy_d    = 1'b0;
              level_d   = LVL_TOP;
              op_o.kind = KIND_PHYS_ADDR;
              op_o.base = {rd[51:30], 30'b0};
              op_o.offs = va_q[29:0];
            end
          end
          LVL_DIR: begin
            if (rd[7]) begin
              busy_d    = 1'b0;
              level_d   = LVL_TOP;
              op_o.kind = KIND_PHYS_ADDR;
              op_o.base = {16'b0, rd[35:21], 21'b0};
              op_o.offs = {9'b0, va_q[20:0]};
            end
          end
          LVL_LEAF: begin
            busy_d    = 1'b0;
            level_d   = LVL_TOP;
            op_o.kind = KIND_PHYS_ADDR;
            op_o.offs = {18'b0, va_q[11:0]};
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      level_q <= LVL_TOP;
      va_q    <= '0;
      prim_q  <= '0;
      sec_q   <= '0;
    end else begin
      busy_q  <= busy_d;
      level_q <= level_d;
      va_q    <= va_d;
      if (cfg_we_i && (cfg_idx_i == REG_PRIMARY_BASE)) begin
        prim_q <= cfg_wdata_i;
      end
      if (cfg_we_i && (cfg_idx_i == REG_SECONDARY_BASE)) begin
        sec_q <= cfg_wdata_i;
      end
    end
  end

endmodule

`default_nettype wire

FILE: src/ptw_back.sv
`default_nettype none

module ptw_back
  import ptw_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    q_valid_i,
  input  wire ptw_op_t q_data_i,
  output logic         q_pop_o,
  output logic         out_valid_o,
  input  wire logic    out_stall_i,
  output ptw_out_t     out_data_o
);

  logic     out_valid_q, out_valid_d;
  ptw_out_t out_data_q, out_data_d;

  assign q_pop_o = q_valid_i && (!out_valid_q || !out_stall_i);

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (q_pop_o) begin
      out_valid_d        = 1'b1;
      out_data_d.kind    = q_data_i.kind;
      out_data_d.address = q_data_i.base + {22'b0, q_data_i.offs};
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

FILE: src/four_level_page_table_walker_core.sv
// Channel   Direction  Handshake                Payload
// in        input      in_valid_i / in_stall_o   in_data_i   (ptw_in_t)
// out       output     out_valid_o / out_stall_i out_data_o  (ptw_out_t)
// cfg       input      cfg_we_i                  cfg_idx_i, cfg_wdata_i
//
// One item is taken per cycle while in_stall_o is low; results are queued, then registered.
// The front stage walks the tables and queues one operation; the back stage adds and registers.
// Items in the wrong phase are accepted and dropped without a result.
// in_stall_o rises only when the QueueDepth-entry queue is full; out_stall_i holds the result.
// Reset clears the walk state, both base registers and the queue; there is no clearing pass.
`default_nettype none

`include "four_level_page_table_walker_core_macros.svh"

module four_level_page_table_walker_core
  import ptw_pkg::*;
#(
  parameter int unsigned QueueDepth = 2
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire ptw_in_t     in_data_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output ptw_out_t         out_data_o,
  input  wire logic        cfg_we_i,
  input  wire logic [0:0]  cfg_idx_i,
  input  wire logic [51:0] cfg_wdata_i
);

  logic    accept;
  logic    push;
  ptw_op_t push_op;
  logic    q_full;
  logic    q_valid;
  logic    q_pop;
  ptw_op_t q_op;

  assign in_stall_o = q_full;
  assign accept     = in_valid_i && !q_full;

  ptw_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .in_data_i   (in_data_i),
    .push_o      (push),
    .op_o        (push_op)
  );

  ptw_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_op),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .data_o      (q_op)
  );

  ptw_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (q_op),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  `PTW_ASSERT_NOW(a_push_only_when_room, push, !q_full, "push into a full queue")
  `PTW_ASSERT_NOW(a_full_not_empty, q_full, q_valid, "queue full yet empty")
  `PTW_ASSERT_NOW(a_pop_only_when_valid, q_pop, q_valid, "pop from an empty queue")
  `PTW_ASSERT_NEXT(a_drain, out_valid_o && !out_stall_i && !q_valid, !out_valid_o,
                   "result shown with nothing queued")

endmodule

`default_nettype wire

FILE: tb/sv/tb_four_level_page_table_walker_core.sv
`timescale 1ns / 100ps

module tb_four_level_page_table_walker_core;
  import ptw_pkg::*;

  class translation_tracker;
    logic [51:0] primary_base;
    logic [51:0] secondary_base;
    bit          walking;
    bit   [1:0]  depth;
    logic [47:0] vaddr;
    ptw_out_t    pending_q[$];
    int          mismatches;
    int          checked;
    int          ignored;
    int          gib_pages;
    int          mib_pages;
    int          kib_pages;

    function new();
      primary_base   = '0;
      secondary_base = '0;
      walking        = 1'b0;
      depth          = '0;
      vaddr          = '0;
      mismatches     = 0;
      checked        = 0;
      ignored        = 0;
      gib_pages      = 0;
      mib_pages      = 0;
      kib_pages      = 0;
    endfunction

    function void write_reg(logic [0:0] idx, logic [51:0] value);
      if (idx == REG_PRIMARY_BASE) begin
        primary_base = value;
      end else begin
        secondary_base = value;
      end
    endfunction

    function logic [51:0] table_entry_addr(logic [51:0] base, int unsigned lvl);
      logic [47:0] shifted;
      logic [51:0] offs;
      shifted = vaddr >> (39 - 9 * lvl);
      offs    = {40'b0, shifted[8:0], 3'b000};
      return base + offs;
    endfunction

    function void accept_request(ptw_in_t item);
      ptw_out_t    res;
      logic [51:0] top;
      logic [63:0] e;
      e = item.read_data;
      if (item.func == FUNC_TRANSLATE) begin
        if (walking) begin
          ignored++;
          return;
        end
        vaddr       = item.virt_addr;
        top         = (primary_base != '0) ? primary_base : {secondary_base[51:4], 4'b0000};
        walking     = 1'b1;
        depth       = 2'd0;
        res.kind    = KIND_READ_REQ;
        res.address = table_entry_addr(top, 0);
      end else begin
        if (!walking) begin
          ignored++;
          return;
        end
        if (depth == 2'd1 && e[7]) begin
          res.kind    = KIND_PHYS_ADDR;
          res.address = {e[51:30], 30'b0} + {22'b0, vaddr[29:0]};
          walking     = 1'b0;
          depth       = 2'd0;
          gib_pages++;
        end else if (depth == 2'd2 && e[7]) begin
          res.kind    = KIND_PHYS_ADDR;
          res.address = {16'b0, e[35:21], 21'b0} + {31'b0, vaddr[20:0]};
          walking     = 1'b0;
          depth       = 2'd0;
          mib_pages++;
        end else if (depth == 2'd3) begin
          res.kind    = KIND_PHYS_ADDR;
          res.address = {16'b0, e[35:12], 12'b0} + {40'b0, vaddr[11:0]};
          walking     = 1'b0;
          depth       = 2'd0;
          kib_pages++;
        end else begin
          depth       = depth + 2'd1;
          res.kind    = KIND_READ_REQ;
          res.address = table_entry_addr({16'b0, e[35:12], 12'b0}, 32'(depth));
        end
      end
      pending_q.push_back(res);
    endfunction

    function void match_result(ptw_out_t got);
      ptw_out_t want;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result, kind %0d address %h", $time, got.kind, got.address);
        mismatches++;
        return;
      end
      want = pending_q.pop_front();
      checked++;
      if (got.kind !== want.kind) begin
        $display("%0t: kind mismatch, expected %0d actual %0d", $time, want.kind, got.kind);
        mismatches++;
      end
      if (got.address !== want.address) begin
        $display("%0t: address mismatch, expected %h actual %h", $time, want.address,
                 got.address);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  ptw_in_t     in_data   = '0;
  logic        out_stall = 1'b0;
  logic        cfg_we    = 1'b0;
  logic [0:0]  cfg_idx   = REG_PRIMARY_BASE;
  logic [51:0] cfg_wdata = '0;
  logic        in_stall;
  logic        out_valid;
  ptw_out_t    out_data;

  translation_tracker tracker = new();

  int   gap_pct        = 0;
  int   stall_pct      = 0;
  bit   hold_req       = 1'b0;
  bit   gen_walking    = 1'b0;
  bit   [1:0] gen_depth = '0;
  int   effective_sent = 0;
  int   items_sent     = 0;

  four_level_page_table_walker_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        tracker.match_result(out_data);
      end
      if (in_valid && !in_stall) begin
        tracker.accept_request(in_data);
      end
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [47:0] rand48();
    logic [63:0] r;
    r = rand64();
    return r[47:0];
  endfunction

  function automatic logic [51:0] rand52();
    logic [63:0] r;
    r = rand64();
    return r[51:0];
  endfunction

  function automatic ptw_in_t make_translate(logic [47:0] va);
    ptw_in_t item;
    item.func      = FUNC_TRANSLATE;
    item.virt_addr = va;
    item.read_data = rand64();
    return item;
  endfunction

  function automatic ptw_in_t make_response(logic [63:0] e);
    ptw_in_t item;
    item.func      = FUNC_READ_RESP;
    item.virt_addr = rand48();
    item.read_data = e;
    return item;
  endfunction

  function automatic int pick_gap();
    if (gap_pct == 0 || $urandom_range(0, 99) >= gap_pct) begin
      return 0;
    end
    if ($urandom_range(0, 9) == 0) begin
      return $urandom_range(20, 60);
    end
    return $urandom_range(1, 3);
  endfunction

  task automatic send_item(input ptw_in_t item);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    items_sent++;
    if (item.func == FUNC_TRANSLATE) begin
      if (!gen_walking) begin
        gen_walking = 1'b1;
        gen_depth   = 2'd0;
        effective_sent++;
      end
    end else if (gen_walking) begin
      effective_sent++;
      if ((gen_depth == 2'd1 && item.read_data[7]) || (gen_depth == 2'd2 && item.read_data[7])
          || gen_depth == 2'd3) begin
        gen_walking = 1'b0;
        gen_depth   = 2'd0;
      end else begin
        gen_depth = gen_depth + 2'd1;
      end
    end
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic configure_bases(input logic [51:0] primary, input logic [51:0] secondary);
    cfg_we    <= 1'b1;
    cfg_idx   <= REG_PRIMARY_BASE;
    cfg_wdata <= primary;
    tracker.write_reg(REG_PRIMARY_BASE, primary);
    @(posedge clk);
    cfg_idx   <= REG_SECONDARY_BASE;
    cfg_wdata <= secondary;
    tracker.write_reg(REG_SECONDARY_BASE, secondary);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_item();
    logic [63:0] e;
    logic [47:0] va;
    int          pick;
    pick = $urandom_range(0, 99);
    e    = rand64();
    va   = rand48();
    if (pick < 3) begin
      va = '1;
      e  = '1;
    end else if (pick < 6) begin
      va = '0;
      e  = '0;
    end
    if (!gen_walking) begin
      if (pick >= 92) begin
        send_item(make_response(e));
      end else begin
        send_item(make_translate(va));
      end
    end else if (pick >= 94) begin
      send_item(make_translate(va));
    end else begin
      if (gen_depth == 2'd1 || gen_depth == 2'd2) begin
        e[7] = ($urandom_range(0, 99) < 30);
      end
      send_item(make_response(e));
    end
  endtask

  initial begin : receiver
    int stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 2);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < 4000) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("FAIL four_level_page_table_walker_core");
    $finish;
  end

  initial begin : stimulus
    logic [51:0] p;
    logic [51:0] s;
    int          target;
    int          ph;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    configure_bases('1, '0);
    send_item(make_translate('1));
    send_item(make_response('1));
    send_item(make_response('1));
    send_item(make_response('1));
    send_item(make_translate('0));
    send_item(make_translate('1));
    send_item(make_response('0));
    send_item(make_response('0));
    send_item(make_response('1));
    send_item(make_translate('1));
    send_item(make_response('1));
    send_item(make_response(64'hFFFF_FFFF_FFFF_FF7F));
    send_item(make_response(64'hFFFF_FFFF_FFFF_FF7F));
    send_item(make_response('1));
    send_item(make_translate(48'h8040_2010_0FFF));
    send_item(make_response(64'h0000_0000_0000_0080));
    send_item(make_response(64'h0000_0000_0000_0000));
    send_item(make_response(64'h0000_0000_0000_0000));
    send_item(make_response(64'h0000_0000_0000_0080));
    drain();
    configure_bases('0, '1);
    send_item(make_translate('1));
    send_item(make_response('0));
    send_item(make_response(64'h0000_0000_0000_0080));
    drain();

    for (ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          p = rand52();
          s = rand52();
          gap_pct   = 0;
          stall_pct = 0;
        end
        1: begin
          p = '0;
          s = rand52();
          gap_pct   = 25;
          stall_pct = 25;
        end
        2: begin
          p = '1;
          s = '1;
          gap_pct   = 50;
          stall_pct = 50;
        end
        3: begin
          p = rand52();
          s = '0;
          gap_pct   = 0;
          stall_pct = 20;
        end
        4: begin
          p = '0;
          s = '0;
          gap_pct   = 15;
          stall_pct = 60;
        end
        default: begin
          p = 52'h1;
          s = '1;
          gap_pct   = 40;
          stall_pct = 10;
        end
      endcase
      configure_bases(p, s);
      if (ph == 3) begin
        hold_req = 1'b1;
      end
      target = effective_sent + 320;
      while (effective_sent < target) random_item();
      drain();
    end

    repeat (20) @(posedge clk);
    $display("Ran %0d items over eight base settings: %0d walks to 1 GiB,",
             items_sent, tracker.gib_pages);
    $display("%0d to 2 MiB and %0d to 4 KiB; %0d out-of-phase items were dropped and %0d %s",
             tracker.mib_pages, tracker.kib_pages, tracker.ignored, tracker.checked,
             "results were checked.");
    if (tracker.mismatches == 0 && tracker.pending_q.size() == 0) begin
      $display("PASS four_level_page_table_walker_core");
    end else begin
      $display("FAIL four_level_page_table_walker_core");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+src
src/ptw_pkg.sv
src/ptw_fifo.sv
src/ptw_front.sv
src/ptw_back.sv
src/four_level_page_table_walker_core.sv
tb/sv/tb_four_level_page_table_walker_core.sv
